// ===== src/raster_slow_axis_waveform_macros.svh =====
// Assertion macros for the slow-axis waveform block.
// Define ASSERT_OFF to compile every assertion away.
`ifndef RASTER_SLOW_AXIS_WAVEFORM_MACROS_SVH
`define RASTER_SLOW_AXIS_WAVEFORM_MACROS_SVH

`ifndef ASSERT_OFF

// Implication checked at every rising edge outside reset.
`define RSAW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never hold outside reset.
`define RSAW_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error(msg);

`else

`define RSAW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RSAW_ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ===== src/rsaw_pkg.sv =====
`default_nettype none
package rsaw_pkg;

	// Default field widths
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int COUNT_WIDTH_DEF  = 16;

	// Q16 fraction arithmetic
	localparam int FRAC_BITS = 16;
	// quotient bits: fractions run from 0 to 1.0 inclusive
	localparam int FRAC_W    = 17;
	// multiplier operand B width (holds up to 3.0 in Q16)
	localparam int MUL_BW    = 18;
	localparam logic [MUL_BW-1:0] SMOOTH_THREE = MUL_BW'(3 << FRAC_BITS);

	// Register reset values
	localparam int ACTIVE_RESET  = 512;
	localparam int FLYBACK_RESET = 16;
	localparam int START_RESET   = -16384;
	localparam int END_RESET     = 16383;

	// Configuration register indexes
	localparam int CFG_INDEX_WIDTH = 2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACTIVE  = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FLYBACK = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_START   = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_END     = 2'd3;

	// Status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

endpackage
`default_nettype wire

// ===== src/rsaw_div.sv =====
`default_nettype none
// Radix-2 restoring divider, one quotient bit per cycle.
// The upper dividend bits must be below the divisor (quotient fits QW bits).
module rsaw_div import rsaw_pkg::*; #(
	parameter int DW = COUNT_WIDTH_DEF,
	parameter int QW = FRAC_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DW+QW-1:0] dividend,
	input  wire logic [DW-1:0]    divisor,
	output logic      [QW-1:0]    quotient,
	output unit_status_t          status
);

	localparam int CNTW = $clog2(QW + 1);

	logic [DW-1:0]   rem_q;
	logic [QW-1:0]   sh_q;
	logic [DW-1:0]   dvs_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [DW+1:0]   trial;
	logic            fit;
	logic [DW-1:0]   rem_next;

	// Trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		trial    = {1'b0, rem_q, sh_q[QW-1]} - {2'b00, dvs_q};
		fit      = ~trial[DW+1];
		rem_next = fit ? trial[DW-1:0] : {rem_q[DW-2:0], sh_q[QW-1]};
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DW+QW-1:QW];
			sh_q  <= dividend[QW-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			sh_q  <= {sh_q[QW-2:0], fit};
		end
	end

	assign quotient    = sh_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule
`default_nettype wire

// ===== src/rsaw_mul.sv =====
`default_nettype none
// Serial shift-add multiplier: signed A times unsigned B, one bit of B per cycle.
// Product low bits shift out into the B register as the sum moves right.
module rsaw_mul import rsaw_pkg::*; #(
	parameter int AW = SAMPLE_WIDTH_DEF + 2,
	parameter int BW = MUL_BW
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [AW-1:0]    a,
	input  wire logic        [BW-1:0]    b,
	output logic signed      [AW+BW-1:0] product,
	output unit_status_t                 status
);

	localparam int CNTW = $clog2(BW + 1);

	logic signed [AW-1:0] a_q;
	logic signed [AW-1:0] hi_q;
	logic [BW-1:0]        lo_q;
	logic [CNTW-1:0]      cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic signed [AW-1:0] addend;
	logic signed [AW:0]   sum;

	// Add A when the current multiplier bit is set
	always_comb begin
		addend = lo_q[0] ? a_q : '0;
		sum    = {hi_q[AW-1], hi_q} + {addend[AW-1], addend};
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Accumulator and multiplier shift register
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[AW:1];
			lo_q <= {sum[0], lo_q[BW-1:1]};
		end
	end

	assign product     = {hi_q, lo_q};
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule
`default_nettype wire

// ===== src/raster_slow_axis_waveform.sv =====
`default_nettype none
// Slow-axis galvo waveform generator, one DAC sample per line-clock tick.
// s_axis: one transaction per line tick; tdata bit 0 is restart_frame, which
//   sends the line position back to 0 before this tick's sample.
// m_axis: one transaction per tick with the sample code, line number, frame
//   pulse level (tdata), the flyback flag (tuser) and the final-line mark (tlast).
// cfg: write port for active_lines, flyback_lines, start_code, end_code
//   (indexes 0..3); writes are taken every cycle and apply to the next tick.
// Timing: a single active line goes straight to the output register; any other
//   line runs the 17-step bit-serial divider, followed by one (scan) or three
//   (flyback) passes of the 18-step bit-serial multiplier, each unit started
//   from its own hand-off state (S_DGO, S_MGO).
// One tick is worked on at a time; the next tick is taken as soon as the result
//   moves to the output register, even while m_axis is stalled. A stalled
//   output holds its transaction; a second finished sample waits in the engine.
// Reset loads the register defaults (512, 16, -16384, 16383), puts the line
//   position at 0 and empties the output register.
`include "raster_slow_axis_waveform_macros.svh"
module raster_slow_axis_waveform import rsaw_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// restart_frame [0]
	input  wire logic [7:0]                 s_axis_tdata,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	// sample_code, line_number, frame_pulse (from bit 0 up), zero padded
	output logic [((SAMPLE_WIDTH+COUNT_WIDTH+2+7)/8)*8-1:0] m_axis_tdata,
	// in_flyback [0]
	output logic [0:0]                      m_axis_tuser,
	output logic                            m_axis_tlast,
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [((COUNT_WIDTH > SAMPLE_WIDTH) ? COUNT_WIDTH : SAMPLE_WIDTH)-1:0]
	                                        cfg_data
);

	localparam int SW  = SAMPLE_WIDTH;
	localparam int CW  = COUNT_WIDTH;
	localparam int LW  = CW + 1;
	localparam int MA  = (SW + 1 > MUL_BW) ? SW + 1 : MUL_BW;
	localparam int PW  = MA + MUL_BW;
	localparam int RW  = PW - FRAC_BITS;
	localparam int TDW = ((SW + LW + 1 + 7) / 8) * 8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DGO,
		S_DIV,
		S_MGO,
		S_MUL,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		M_SQ,
		M_SMOOTH,
		M_LERP
	} mop_t;

	// Configuration registers
	logic [CW-1:0]        act_cfg_q;
	logic [CW-1:0]        fly_cfg_q;
	logic signed [SW-1:0] start_q;
	logic signed [SW-1:0] end_q;

	// Sequencer state and per-tick working registers
	state_t               state_q;
	mop_t                 mop_q;
	logic [LW-1:0]        lc_q;
	logic [LW-1:0]        line_q;
	logic                 fly_q;
	logic                 fp_q;
	logic                 fe_q;
	logic [CW-1:0]        x_q;
	logic [CW-1:0]        d_q;
	logic signed [SW:0]   diff_q;
	logic signed [SW-1:0] base_q;
	logic [MUL_BW-1:0]    frac_q;
	logic [FRAC_W-1:0]    q_q;
	logic signed [SW-1:0] code_q;

	// Output register
	logic                 out_valid_q;
	logic signed [SW-1:0] out_code_q;
	logic [LW-1:0]        out_line_q;
	logic                 out_fly_q;
	logic                 out_fp_q;
	logic                 out_fe_q;

	// Tick decode
	logic [CW-1:0]        act;
	logic [CW-1:0]        fly;
	logic [LW-1:0]        frame_len;
	logic [LW-1:0]        line;
	logic [LW-1:0]        line_inc;
	logic [LW-1:0]        lc_next;
	logic                 is_fly;
	logic                 single;
	logic                 in_acc;
	logic                 load_out;

	// Arithmetic units
	logic [CW+FRAC_W-1:0] div_dividend;
	logic [FRAC_W-1:0]    div_quot;
	unit_status_t         div_st;
	logic                 div_start;
	logic signed [MA-1:0] mul_a;
	logic [MUL_BW-1:0]    mul_b;
	logic signed [PW-1:0] mul_prod;
	unit_status_t         mul_st;
	logic                 mul_start;
	logic signed [PW-1:0] prod_rnd;
	logic [RW-1:0]        prod_r;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign load_out      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	// Decode line position and frame flags for an incoming tick
	always_comb begin
		act       = (act_cfg_q == '0) ? CW'(1) : act_cfg_q;
		fly       = (fly_cfg_q == '0) ? CW'(1) : fly_cfg_q;
		frame_len = {1'b0, act} + {1'b0, fly};
		line      = (s_axis_tdata[0] || (lc_q >= frame_len)) ? '0 : lc_q;
		line_inc  = line + 1'b1;
		lc_next   = (line_inc >= frame_len) ? '0 : line_inc;
		is_fly    = (line >= {1'b0, act});
		single    = !is_fly && (act == CW'(1));
	end

	// Unit operands
	always_comb begin
		div_dividend = {1'b0, x_q, FRAC_BITS'(0)} + (CW + FRAC_W)'(d_q >> 1);
		div_start    = (state_q == S_DGO);
		mul_start    = (state_q == S_MGO);
		case (mop_q)
			M_SQ: begin
				mul_a = MA'(frac_q);
				mul_b = frac_q;
			end
			M_SMOOTH: begin
				mul_a = MA'(q_q);
				mul_b = SMOOTH_THREE - {frac_q[MUL_BW-2:0], 1'b0};
			end
			M_LERP: begin
				mul_a = MA'(diff_q);
				mul_b = frac_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod_rnd = mul_prod + (PW'(1) << (FRAC_BITS - 1));
		prod_r   = prod_rnd[PW-1:FRAC_BITS];
	end

	rsaw_div #(
		.DW (CW),
		.QW (FRAC_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (d_q),
		.quotient (div_quot),
		.status   (div_st)
	);

	rsaw_mul #(
		.AW (MA),
		.BW (MUL_BW)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.product (mul_prod),
		.status  (mul_st)
	);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_cfg_q <= CW'(ACTIVE_RESET);
			fly_cfg_q <= CW'(FLYBACK_RESET);
			start_q   <= SW'(START_RESET);
			end_q     <= SW'(END_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ACTIVE:  act_cfg_q <= cfg_data[CW-1:0];
				REG_FLYBACK: fly_cfg_q <= cfg_data[CW-1:0];
				REG_START:   start_q   <= cfg_data[SW-1:0];
				REG_END:     end_q     <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	// Sequence one tick through divider and multiplier (skipped for a single active line), then hand off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mop_q       <= M_SQ;
			lc_q        <= '0;
			line_q      <= '0;
			fly_q       <= 1'b0;
			fp_q        <= 1'b0;
			fe_q        <= 1'b0;
			x_q         <= '0;
			d_q         <= '0;
			diff_q      <= '0;
			base_q      <= '0;
			frac_q      <= '0;
			q_q         <= '0;
			code_q      <= '0;
			out_valid_q <= 1'b0;
			out_code_q  <= '0;
			out_line_q  <= '0;
			out_fly_q   <= 1'b0;
			out_fp_q    <= 1'b0;
			out_fe_q    <= 1'b0;
		end else begin
			// load or drain the output register
			if (load_out) begin
				out_valid_q <= 1'b1;
				out_code_q  <= code_q;
				out_line_q  <= line_q;
				out_fly_q   <= fly_q;
				out_fp_q    <= fp_q;
				out_fe_q    <= fe_q;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						lc_q   <= lc_next;
						line_q <= line;
						fly_q  <= is_fly;
						fp_q   <= (line >= frame_len - LW'(2));
						fe_q   <= (line == frame_len - LW'(1));
						if (is_fly) begin
							x_q    <= CW'(line - {1'b0, act} + 1'b1);
							d_q    <= fly;
							diff_q <= {start_q[SW-1], start_q} - {end_q[SW-1], end_q};
							base_q <= end_q;
						end else begin
							x_q    <= line[CW-1:0];
							d_q    <= act - 1'b1;
							diff_q <= {end_q[SW-1], end_q} - {start_q[SW-1], start_q};
							base_q <= start_q;
						end
						if (single) begin
							code_q  <= start_q;
							state_q <= S_DONE;
						end else begin
							state_q <= S_DGO;
						end
					end
				end
				S_DGO: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_st.done) begin
						frac_q  <= MUL_BW'(div_quot);
						mop_q   <= fly_q ? M_SQ : M_LERP;
						state_q <= S_MGO;
					end
				end
				S_MGO: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mul_st.done) begin
						case (mop_q)
							M_SQ: begin
								q_q     <= prod_r[FRAC_W-1:0];
								mop_q   <= M_SMOOTH;
								state_q <= S_MGO;
							end
							M_SMOOTH: begin
								frac_q  <= prod_r[MUL_BW-1:0];
								mop_q   <= M_LERP;
								state_q <= S_MGO;
							end
							default: begin
								code_q  <= base_q + prod_r[SW-1:0];
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = TDW'({out_fp_q, out_line_q, out_code_q});
	assign m_axis_tuser[0] = out_fly_q;
	assign m_axis_tlast    = out_fe_q;

	// The final line of a frame is always a return line inside the pulse
	`RSAW_ASSERT_IMP(a_end_in_pulse, clk, arst_n, m_axis_tvalid && m_axis_tlast,
		m_axis_tdata[SW+LW], "frame end outside frame pulse")
	`RSAW_ASSERT_IMP(a_end_in_flyback, clk, arst_n, m_axis_tvalid && m_axis_tlast,
		m_axis_tuser[0], "frame end outside flyback")
	// Divider and multiplier run one after the other, never together
	`RSAW_ASSERT_NEVER(a_units_serial, clk, arst_n, div_st.busy && mul_st.busy,
		"divider and multiplier busy at once")

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import rsaw_pkg::*;

	typedef struct packed {
		logic [15:0] code;
		logic [16:0] line;
		logic        flyback;
		logic        pulse;
		logic        last;
	} sample_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_ACTIVE;
	logic [15:0] cfg_data = '0;

	// Register shadow and line position of the expected waveform
	logic [15:0]        act_reg = 16'(ACTIVE_RESET);
	logic [15:0]        fly_reg = 16'(FLYBACK_RESET);
	logic signed [15:0] start_reg = 16'(START_RESET);
	logic signed [15:0] end_reg = 16'(END_RESET);
	longint             line_pos = 0;

	bit      restart_q[$];
	sample_t sample_q[$];
	int      errors = 0;

	// Handshake bookkeeping for the driver and the receiver
	logic in_taken = 1'b0;
	logic out_taken = 1'b0;
	int   in_wait = 0;
	int   out_wait = 0;
	bit   tx_burst = 1'b0;
	bit   rx_burst = 1'b0;
	bit   squeeze_req = 1'b0;
	bit   rx_hold = 1'b0;

	raster_slow_axis_waveform dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// base + round(diff * frac / 2^16), ties upward
	function automatic longint lerp_q16(longint base, longint diff, longint frac);
		return base + ((diff * frac + 32768) >>> 16);
	endfunction

	// Sample for the next line tick; advances the line position
	function automatic sample_t next_sample(bit restart);
		longint act, fly, frame_len, line, den, frac, k, t, q, s;
		sample_t r;
		act = (act_reg == 0) ? 1 : longint'(act_reg);
		fly = (fly_reg == 0) ? 1 : longint'(fly_reg);
		frame_len = act + fly;
		if (restart || line_pos >= frame_len)
			line_pos = 0;
		line = line_pos;
		if (line < act) begin
			r.flyback = 1'b0;
			if (act == 1) begin
				r.code = start_reg;
			end else begin
				den = act - 1;
				frac = (line * 65536 + den / 2) / den;
				r.code = 16'(lerp_q16(start_reg, longint'(end_reg) - start_reg, frac));
			end
		end else begin
			// smoothstep return from end to start
			k = line - act;
			t = ((k + 1) * 65536 + fly / 2) / fly;
			q = (t * t + 32768) >> 16;
			s = (q * (196608 - 2 * t) + 32768) >> 16;
			r.flyback = 1'b1;
			r.code = 16'(lerp_q16(end_reg, longint'(start_reg) - end_reg, s));
		end
		r.line = 17'(line);
		r.pulse = (line >= frame_len - 2);
		r.last = (line == frame_len - 1);
		line_pos = line + 1;
		if (line_pos >= frame_len)
			line_pos = 0;
		return r;
	endfunction

	function automatic int pick_gap(bit burst);
		return burst ? 0 : $urandom_range(0, 17);
	endfunction

	function automatic int pick_code();
		case ($urandom_range(0, 5))
			0: return -32768;
			1: return 32767;
			2: return 0;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// Sample every transaction at the rising edge
	always @(posedge clk) begin
		sample_t want, got;
		in_taken <= s_axis_tvalid && s_axis_tready;
		out_taken <= m_axis_tvalid && m_axis_tready;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ACTIVE:  act_reg <= cfg_data;
				REG_FLYBACK: fly_reg <= cfg_data;
				REG_START:   start_reg <= cfg_data;
				REG_END:     end_reg <= cfg_data;
				default: ;
			endcase
		end
		if (s_axis_tvalid && s_axis_tready)
			sample_q.insert(sample_q.size(), next_sample(s_axis_tdata[0]));
		if (m_axis_tvalid && m_axis_tready) begin
			got.code = m_axis_tdata[15:0];
			got.line = m_axis_tdata[32:16];
			got.pulse = m_axis_tdata[33];
			got.flyback = m_axis_tuser[0];
			got.last = m_axis_tlast;
			if (sample_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected sample: code %0d line %0d", $signed(got.code),
						got.line);
			end else begin
				want = sample_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("sample mismatch: expected code %0d line %0d ",
							$signed(want.code), want.line,
							"fly %0b pulse %0b last %0b, ",
							want.flyback, want.pulse, want.last,
							"got code %0d line %0d ", $signed(got.code), got.line,
							"fly %0b pulse %0b last %0b",
							got.flyback, got.pulse, got.last);
				end
			end
		end
	end

	// Drive line ticks from the queue, with a random gap after each transaction
	always @(negedge clk) begin
		if (in_taken)
			in_wait = pick_gap(tx_burst);
		if (s_axis_tvalid && !in_taken) begin
			// hold until accepted
		end else if (in_wait != 0) begin
			s_axis_tvalid <= 1'b0;
			in_wait--;
		end else if (restart_q.size() != 0) begin
			s_axis_tdata <= {7'd0, restart_q.pop_front()};
			s_axis_tvalid <= 1'b1;
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// Stall the output side after each transaction, or during a long hold
	always @(negedge clk) begin
		if (out_taken)
			out_wait = pick_gap(rx_burst);
		if (rx_hold || out_wait != 0) begin
			m_axis_tready <= 1'b0;
			if (!rx_hold)
				out_wait--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Long output hold so the block backs up and stalls its input
	initial begin
		wait (squeeze_req);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (600) @(posedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("FAIL raster_slow_axis_waveform");
		$finish;
	end

	task automatic drain();
		while (restart_q.size() != 0 || s_axis_tvalid || sample_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write the registers picked by mask, back to back
	task automatic set_regs(input bit [3:0] mask, input int act, input int fly,
		input int st, input int en);
		int vals[4];
		vals = '{act, fly, st, en};
		for (int i = 0; i < 4; i++) begin
			if (mask[i]) begin
				@(negedge clk);
				cfg_valid <= 1'b1;
				cfg_index <= CFG_INDEX_WIDTH'(i);
				cfg_data <= 16'(vals[i]);
				do @(posedge clk); while (!(cfg_valid && cfg_ready));
			end
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int act, fly;
		bit noisy;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(posedge clk);

		// Reset defaults, restart first
		restart_q = '{1, 0, 0};
		drain();
		// Single scan line with flyback of zero, code extremes
		set_regs(4'hF, 1, 0, -32768, 32767);
		restart_q = '{0, 0, 1, 0};
		drain();
		// Zero active lines, one flyback line, reversed extremes
		set_regs(4'hF, 0, 1, 32767, -32768);
		restart_q = '{0, 1, 0};
		drain();
		// Short frame through its full ramp and a wrap, restart mid-frame
		set_regs(4'hF, 3, 2, -32768, 32767);
		restart_q = '{1, 0, 0, 0, 0, 0, 0, 1};
		drain();
		// Largest frame
		set_regs(4'hF, 65535, 65535, 32767, -32768);
		restart_q = '{0, 0, 0};
		drain();
		// Shrink the frame below the line position so it wraps
		set_regs(4'h3, 1, 2, 0, 0);
		restart_q = '{0, 0, 0};
		drain();

		// Random frames, mostly continuous with occasional restarts
		for (int p = 0; p < 20; p++) begin
			act = (p % 6 == 5) ? $urandom_range(300, 65535) : $urandom_range(0, 40);
			if (p % 5 == 4)
				fly = $urandom_range(0, 1);
			else if (p % 6 == 5)
				fly = $urandom_range(2, 65535);
			else
				fly = $urandom_range(2, 24);
			set_regs((p < 2) ? 4'hF : 4'($urandom_range(1, 15)), act, fly, pick_code(),
				pick_code());
			tx_burst = (p % 3 == 1) || (p == 2);
			rx_burst = (p % 4 == 3);
			noisy = (p % 4 == 1);
			for (int i = 0; i < 96; i++)
				restart_q.insert(restart_q.size(), noisy ? ($urandom_range(0, 3) == 0) :
					($urandom_range(0, 49) == 0));
			if (p == 2)
				squeeze_req = 1'b1;
			drain();
		end

		repeat (100) @(posedge clk);
		if (errors == 0 && sample_q.size() == 0)
			$display("PASS raster_slow_axis_waveform");
		else
			$display("FAIL raster_slow_axis_waveform");
		$finish;
	end

endmodule
